[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fws_pkg.sv]
// Types, constants and helper functions of the flush/FUA write sequencer.
`default_nettype none
package fws_pkg;

    localparam int TagCount = 16;
    localparam int TagW     = $clog2(TagCount);
    localparam int CntW     = $clog2(TagCount + 1);
    localparam int AddrW    = TagW + 1;

    localparam logic [2:0] SEQ_PRE  = 3'b001;
    localparam logic [2:0] SEQ_DATA = 3'b010;
    localparam logic [2:0] SEQ_POST = 3'b100;

    localparam logic [1:0] CFG_WBC     = 2'd0;
    localparam logic [1:0] CFG_FUA     = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [15:0] TimeoutReset = 16'd500;

    typedef enum logic [1:0] {
        ACT_INSERT     = 2'd0,
        ACT_DATA_DONE  = 2'd1,
        ACT_FLUSH_DONE = 2'd2,
        ACT_TICK       = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_FINISH = 3'd0,
        KIND_PASS   = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_FLUSH  = 3'd3,
        KIND_DONE   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STEP_PRE,
        STEP_DATA,
        STEP_POST,
        STEP_DONE
    } t_step;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_READ,
        ST_ADV,
        ST_TRYF,
        ST_FIN
    } t_state;

    // First step of a sequence that has not been done yet.
    function automatic t_step next_step(input logic [2:0] s);
        t_step st;
        priority if (!s[0]) st = STEP_PRE;
        else if (!s[1]) st = STEP_DATA;
        else if (!s[2]) st = STEP_POST;
        else st = STEP_DONE;
        return st;
    endfunction

    function automatic logic [2:0] step_mask(input t_step st);
        logic [2:0] m;
        unique case (st)
            STEP_PRE:  m = SEQ_PRE;
            STEP_DATA: m = SEQ_DATA;
            STEP_POST: m = SEQ_POST;
            default:   m = 3'b000;
        endcase
        return m;
    endfunction

    // Ring index wrap for a queue of TagCount entries.
    function automatic logic [TagW-1:0] wrap_idx(input logic [CntW:0] v);
        return TagW'(v % TagCount);
    endfunction

endpackage
`default_nettype wire

[hw/rtl/fws_wait_ram.sv]
// Wait-queue storage: both ring queues in one memory with a registered read port.
`default_nettype none
module fws_wait_ram (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [fws_pkg::AddrW-1:0] i_waddr,
    input  wire logic [fws_pkg::TagW-1:0]  i_wdata,
    input  wire logic                     i_re,
    input  wire logic [fws_pkg::AddrW-1:0] i_raddr,
    output logic      [fws_pkg::TagW-1:0]  o_rdata
);

    logic [fws_pkg::TagW-1:0] r_mem [2*fws_pkg::TagCount];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[hw/rtl/flush_fua_write_sequencer.sv]
// Top level of the flush/FUA write sequencer: event sequencer, tag state and output stage.
//
// The block takes one event item at a time on the input channel (i_valid/o_ready):
// insert a request, data step done, flush done, or a timer tick. It answers with
// zero or more result items on the output channel (o_valid/i_ready), the final one
// of each event marked by o_last. o_ready is high only while the sequencer is idle.
// A tick gives no result. A flush-done event walks the waiting queue of the flush
// side one request per pass through a small sequencer (pop, memory read, advance,
// flush check). Results go through a holding register and an output register, so
// one result can wait for the receiver while the next is formed. When the receiver
// stalls, the sequencer stops in place until a slot frees; no result is lost or
// reordered. Reset is synchronous and active low: it clears all per-tag state, queue
// pointers, counters and time, and sets the configuration to its defaults. The queue
// memory itself is not cleared; entries are only read after they have been written.
// Configuration writes (i_cfg_we) take effect at once and are meant for idle time.
`default_nettype none
module flush_fua_write_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_req_tag,
    input  wire logic        i_has_data,
    input  wire logic        i_want_flush,
    input  wire logic        i_want_fua,
    input  wire logic        i_error,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_kind,
    output logic [3:0]       o_out_tag,
    output logic             o_fua_kept,
    output logic             o_out_error,
    output logic             o_last
);

    localparam int TC = fws_pkg::TagCount;
    localparam int TW = fws_pkg::TagW;
    localparam int CW = fws_pkg::CntW;

    // Configuration.
    logic        r_wbc;
    logic        r_dev_fua;
    logic [15:0] r_timeout;

    // Latched event.
    fws_pkg::t_action r_action;
    logic [3:0]       r_tag;
    logic             r_has_data;
    logic             r_want_flush;
    logic             r_want_fua;
    logic             r_err;

    // Per-tag state.
    logic [2:0] r_steps   [TC];
    logic       r_tag_fua [TC];
    logic       r_busy    [TC];
    logic       r_in_data [TC];

    // Queue pointers and flush bookkeeping.
    logic [TW-1:0] r_heads  [2];
    logic [CW-1:0] r_counts [2];
    logic [CW-1:0] r_dif;
    logic          r_pend_side;
    logic          r_run_side;
    logic [31:0]   r_pend_since;
    logic [31:0]   r_time;

    // Sequencer working registers.
    fws_pkg::t_state r_state;
    fws_pkg::t_state n_state;
    logic            r_in_flush;
    logic            r_side_r;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_i;
    logic [TW-1:0]   r_cur_tag;
    logic            r_cur_err;

    // Holding and output registers.
    logic            r_hold_v;
    fws_pkg::t_kind  r_hold_kind;
    logic [3:0]      r_hold_tag;
    logic            r_hold_fua;
    logic            r_hold_err;
    logic            r_out_v;
    fws_pkg::t_kind  r_out_kind;
    logic [3:0]      r_out_tag;
    logic            r_out_fua;
    logic            r_out_err;
    logic            r_out_last;

    // Combinational control.
    logic            em_v;
    fws_pkg::t_kind  em_kind;
    logic [3:0]      em_tag;
    logic            em_fua;
    logic            em_err;
    logic            fin_push;
    logic            can_emit;
    logic [TW-1:0]   ctag;
    logic            tag_bad;
    logic [2:0]      policy;
    logic            ins_fua;
    fws_pkg::t_step  adv_step;
    logic            pop_go;
    logic [31:0]     elapsed;
    logic            flush_ok;
    logic            ram_we;
    logic            ram_re;
    logic [TW-1:0]   ram_rdata;
    logic [TW-1:0]   wr_idx;

    assign can_emit = !r_hold_v || !r_out_v;
    assign ctag     = TW'(r_tag);
    assign tag_bad  = int'(r_tag) >= TC;
    assign ins_fua  = r_want_fua & r_dev_fua;
    assign policy   = {r_wbc & !r_dev_fua & r_want_fua, r_has_data, r_wbc & r_want_flush};
    assign adv_step = r_cur_err ? fws_pkg::STEP_DONE : fws_pkg::next_step(r_steps[r_cur_tag]);
    assign pop_go   = (r_i < r_cnt) && (r_counts[r_side_r] != '0);

    // A waiting flush is deferred while data is in flight and the queue is still young.
    assign elapsed  = r_time - r_pend_since - {16'd0, r_timeout};
    assign flush_ok = (r_pend_side == r_run_side) && (r_counts[r_pend_side] != '0)
                      && !((r_dif != '0) && elapsed[31]);

    assign wr_idx = fws_pkg::wrap_idx((CW+1)'(r_heads[r_pend_side])
                                      + (CW+1)'(r_counts[r_pend_side]));
    assign ram_we = (r_state == fws_pkg::ST_ADV)
                    && (adv_step == fws_pkg::STEP_PRE || adv_step == fws_pkg::STEP_POST)
                    && (int'(r_counts[r_pend_side]) < TC);
    assign ram_re = (r_state == fws_pkg::ST_POP) && pop_go;

    fws_wait_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_pend_side, wr_idx}),
        .i_wdata (r_cur_tag),
        .i_re    (ram_re),
        .i_raddr ({r_side_r, r_heads[r_side_r]}),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and result generation.
    always_comb begin
        n_state  = r_state;
        em_v     = 1'b0;
        em_kind  = fws_pkg::KIND_FINISH;
        em_tag   = r_tag;
        em_fua   = 1'b0;
        em_err   = 1'b0;
        fin_push = 1'b0;
        unique case (r_state)
            fws_pkg::ST_IDLE: begin
                if (i_valid) n_state = fws_pkg::ST_EXEC;
            end
            fws_pkg::ST_EXEC: begin
                unique case (r_action)
                    fws_pkg::ACT_TICK: n_state = fws_pkg::ST_FIN;
                    fws_pkg::ACT_FLUSH_DONE: begin
                        n_state = (r_pend_side == r_run_side) ? fws_pkg::ST_FIN
                                                              : fws_pkg::ST_POP;
                    end
                    fws_pkg::ACT_DATA_DONE: begin
                        n_state = (tag_bad || !r_busy[ctag] || !r_in_data[ctag])
                                  ? fws_pkg::ST_FIN : fws_pkg::ST_ADV;
                    end
                    default: begin
                        if (tag_bad || r_busy[ctag]) begin
                            n_state = fws_pkg::ST_FIN;
                        end else if (policy == 3'b000 || policy == fws_pkg::SEQ_DATA) begin
                            if (can_emit) begin
                                em_v    = 1'b1;
                                em_kind = (policy == 3'b000) ? fws_pkg::KIND_FINISH
                                                             : fws_pkg::KIND_PASS;
                                em_fua  = (policy == 3'b000) ? 1'b0 : ins_fua;
                                n_state = fws_pkg::ST_FIN;
                            end
                        end else begin
                            n_state = fws_pkg::ST_ADV;
                        end
                    end
                endcase
            end
            fws_pkg::ST_POP: begin
                n_state = pop_go ? fws_pkg::ST_READ : fws_pkg::ST_FIN;
            end
            fws_pkg::ST_READ: n_state = fws_pkg::ST_ADV;
            fws_pkg::ST_ADV: begin
                if (adv_step == fws_pkg::STEP_DATA || adv_step == fws_pkg::STEP_DONE) begin
                    if (can_emit) begin
                        em_v    = 1'b1;
                        em_tag  = 4'(r_cur_tag);
                        if (adv_step == fws_pkg::STEP_DATA) begin
                            em_kind = fws_pkg::KIND_DATA;
                            em_fua  = r_tag_fua[r_cur_tag];
                        end else begin
                            em_kind = fws_pkg::KIND_DONE;
                            em_err  = r_cur_err;
                        end
                        n_state = fws_pkg::ST_TRYF;
                    end
                end else begin
                    n_state = fws_pkg::ST_TRYF;
                end
            end
            fws_pkg::ST_TRYF: begin
                if (!flush_ok || can_emit) begin
                    n_state = r_in_flush ? fws_pkg::ST_POP : fws_pkg::ST_FIN;
                end
                if (flush_ok && can_emit) begin
                    em_v    = 1'b1;
                    em_kind = fws_pkg::KIND_FLUSH;
                    em_tag  = 4'd0;
                end
            end
            fws_pkg::ST_FIN: begin
                if (!r_hold_v) begin
                    n_state = fws_pkg::ST_IDLE;
                end else if (!r_out_v) begin
                    fin_push = 1'b1;
                    n_state  = fws_pkg::ST_IDLE;
                end
            end
            default: n_state = fws_pkg::ST_IDLE;
        endcase
    end

    // Datapath and bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbc        <= 1'b0;
            r_dev_fua    <= 1'b0;
            r_timeout    <= fws_pkg::TimeoutReset;
            r_action     <= fws_pkg::ACT_INSERT;
            r_tag        <= '0;
            r_has_data   <= 1'b0;
            r_want_flush <= 1'b0;
            r_want_fua   <= 1'b0;
            r_err        <= 1'b0;
            for (int k = 0; k < TC; k++) begin
                r_steps[k]   <= '0;
                r_tag_fua[k] <= 1'b0;
                r_busy[k]    <= 1'b0;
                r_in_data[k] <= 1'b0;
            end
            for (int k = 0; k < 2; k++) begin
                r_heads[k]  <= '0;
                r_counts[k] <= '0;
            end
            r_dif        <= '0;
            r_pend_side  <= 1'b0;
            r_run_side   <= 1'b0;
            r_pend_since <= '0;
            r_time       <= '0;
            r_in_flush   <= 1'b0;
            r_side_r     <= 1'b0;
            r_cnt        <= '0;
            r_i          <= '0;
            r_cur_tag    <= '0;
            r_cur_err    <= 1'b0;
            r_hold_v     <= 1'b0;
            r_hold_kind  <= fws_pkg::KIND_FINISH;
            r_hold_tag   <= '0;
            r_hold_fua   <= 1'b0;
            r_hold_err   <= 1'b0;
            r_out_v      <= 1'b0;
            r_out_kind   <= fws_pkg::KIND_FINISH;
            r_out_tag    <= '0;
            r_out_fua    <= 1'b0;
            r_out_err    <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    fws_pkg::CFG_WBC:     r_wbc     <= i_cfg_data[0];
                    fws_pkg::CFG_FUA:     r_dev_fua <= i_cfg_data[0];
                    fws_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_v && i_ready) r_out_v <= 1'b0;

            // A new result pushes the held one out, which is then known not to be last.
            if (em_v) begin
                if (r_hold_v) begin
                    r_out_v    <= 1'b1;
                    r_out_kind <= r_hold_kind;
                    r_out_tag  <= r_hold_tag;
                    r_out_fua  <= r_hold_fua;
                    r_out_err  <= r_hold_err;
                    r_out_last <= 1'b0;
                end
                r_hold_v    <= 1'b1;
                r_hold_kind <= em_kind;
                r_hold_tag  <= em_tag;
                r_hold_fua  <= em_fua;
                r_hold_err  <= em_err;
            end
            if (fin_push) begin
                r_out_v    <= 1'b1;
                r_out_kind <= r_hold_kind;
                r_out_tag  <= r_hold_tag;
                r_out_fua  <= r_hold_fua;
                r_out_err  <= r_hold_err;
                r_out_last <= 1'b1;
                r_hold_v   <= 1'b0;
            end

            unique case (r_state)
                fws_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_action     <= fws_pkg::t_action'(i_action);
                        r_tag        <= i_req_tag;
                        r_has_data   <= i_has_data;
                        r_want_flush <= i_want_flush;
                        r_want_fua   <= i_want_fua;
                        r_err        <= i_error;
                    end
                end
                fws_pkg::ST_EXEC: begin
                    unique case (r_action)
                        fws_pkg::ACT_TICK: r_time <= r_time + 32'd1;
                        fws_pkg::ACT_FLUSH_DONE: begin
                            if (r_pend_side != r_run_side) begin
                                r_side_r   <= r_run_side;
                                r_run_side <= !r_run_side;
                                r_cnt      <= r_counts[r_run_side];
                                r_i        <= '0;
                                r_in_flush <= 1'b1;
                            end
                        end
                        fws_pkg::ACT_DATA_DONE: begin
                            if (!tag_bad && r_busy[ctag] && r_in_data[ctag]) begin
                                r_in_data[ctag] <= 1'b0;
                                if (r_dif != '0) r_dif <= r_dif - CW'(1);
                                r_steps[ctag] <= r_steps[ctag] | fws_pkg::SEQ_DATA;
                                r_cur_tag     <= ctag;
                                r_cur_err     <= r_err;
                                r_in_flush    <= 1'b0;
                            end
                        end
                        default: begin
                            if (!tag_bad && !r_busy[ctag] && policy != 3'b000
                                    && policy != fws_pkg::SEQ_DATA) begin
                                r_steps[ctag]   <= ~policy;
                                r_tag_fua[ctag] <= ins_fua;
                                r_busy[ctag]    <= 1'b1;
                                r_in_data[ctag] <= 1'b0;
                                r_cur_tag       <= ctag;
                                r_cur_err       <= 1'b0;
                                r_in_flush      <= 1'b0;
                            end
                        end
                    endcase
                end
                fws_pkg::ST_POP: begin
                    if (pop_go) begin
                        r_heads[r_side_r]  <= fws_pkg::wrap_idx((CW+1)'(r_heads[r_side_r])
                                                                + (CW+1)'(1));
                        r_counts[r_side_r] <= r_counts[r_side_r] - CW'(1);
                        r_i                <= r_i + CW'(1);
                    end
                end
                fws_pkg::ST_READ: begin
                    r_steps[ram_rdata] <= r_steps[ram_rdata]
                        | fws_pkg::step_mask(fws_pkg::next_step(r_steps[ram_rdata]));
                    r_cur_tag <= ram_rdata;
                    r_cur_err <= r_err;
                end
                fws_pkg::ST_ADV: begin
                    unique case (adv_step)
                        fws_pkg::STEP_DATA: begin
                            if (can_emit) begin
                                r_in_data[r_cur_tag] <= 1'b1;
                                r_dif                <= r_dif + CW'(1);
                            end
                        end
                        fws_pkg::STEP_DONE: begin
                            if (can_emit) begin
                                r_busy[r_cur_tag]    <= 1'b0;
                                r_in_data[r_cur_tag] <= 1'b0;
                            end
                        end
                        default: begin
                            if (r_counts[r_pend_side] == '0) r_pend_since <= r_time;
                            if (int'(r_counts[r_pend_side]) < TC) begin
                                r_counts[r_pend_side] <= r_counts[r_pend_side] + CW'(1);
                            end
                        end
                    endcase
                end
                fws_pkg::ST_TRYF: begin
                    if (flush_ok && can_emit) r_pend_side <= !r_pend_side;
                end
                default: ;
            endcase
        end
    end

    assign o_ready     = (r_state == fws_pkg::ST_IDLE);
    assign o_valid     = r_out_v;
    assign o_kind      = r_out_kind;
    assign o_out_tag   = r_out_tag;
    assign o_fua_kept  = r_out_fua;
    assign o_out_error = r_out_err;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

[hw/rtl/fws_checker.sv]
// Port-level checker of the sequencer and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module fws_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [2:0] o_kind,
    input wire logic [3:0] o_out_tag,
    input wire logic       o_fua_kept,
    input wire logic       o_out_error,
    input wire logic       o_last
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_kind) && $stable(o_out_tag) && $stable(o_last), "output item changed while stalled")

    `ASSERT_SAME(a_flush_clean, i_clk, i_rst_n, o_valid && o_kind == fws_pkg::KIND_FLUSH, o_out_tag == 4'd0 && !o_fua_kept && !o_out_error, "flush item carries request fields")

    `ASSERT_SAME(a_err_only_done, i_clk, i_rst_n, o_valid && o_out_error, o_kind == fws_pkg::KIND_DONE, "error flag on an item other than completion")

    `ASSERT_SAME(a_single_last, i_clk, i_rst_n, o_valid && (o_kind == fws_pkg::KIND_FINISH || o_kind == fws_pkg::KIND_PASS), o_last, "finish or pass-through item not marked last")

endmodule

bind flush_fua_write_sequencer fws_checker u_fws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_kind      (o_kind),
    .o_out_tag   (o_out_tag),
    .o_fua_kept  (o_fua_kept),
    .o_out_error (o_out_error),
    .o_last      (o_last)
);
`default_nettype wire

[sim/tb_flush_fua_write_sequencer.sv]
// Self-checking testbench for the flush/FUA write sequencer, with its own event predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_flush_fua_write_sequencer;

    localparam int  LIMIT_CYCLES = 2_000_000;
    localparam int  SETTLE       = 120;
    localparam int  TAGS         = 16;

    // One event item as offered on the input channel.
    typedef struct packed {
        fws_pkg::t_action action;
        logic [3:0]       tag;
        logic             has_data;
        logic             want_flush;
        logic             want_fua;
        logic             err;
    } t_event;

    // One result item as the block should produce it.
    typedef struct packed {
        fws_pkg::t_kind kind;
        logic [3:0]     tag;
        logic           fua;
        logic           err;
        logic           last;
    } t_result;

    // Scoreboard: tracks the sequencer state, predicts results and checks them.
    class seq_board;
        t_result     owed[$];
        int          mismatches;
        logic        wbc;
        logic        dev_fua;
        logic [15:0] hold_ticks;
        logic [2:0]  steps[TAGS];
        logic        tfua[TAGS];
        logic        busy[TAGS];
        logic        in_data[TAGS];
        logic [3:0]  queue_mem[2][TAGS];
        int          head[2];
        int          count[2];
        int          data_live;
        logic        pside;
        logic        rside;
        logic [31:0] since;
        logic [31:0] now;

        function new();
            mismatches = 0;
            wbc = 1'b0;
            dev_fua = 1'b0;
            hold_ticks = fws_pkg::TimeoutReset;
            for (int i = 0; i < TAGS; i++) begin
                steps[i] = '0;
                tfua[i] = 1'b0;
                busy[i] = 1'b0;
                in_data[i] = 1'b0;
            end
            head = '{0, 0};
            count = '{0, 0};
            data_live = 0;
            pside = 1'b0;
            rside = 1'b0;
            since = '0;
            now = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                fws_pkg::CFG_WBC:     wbc = val[0];
                fws_pkg::CFG_FUA:     dev_fua = val[0];
                fws_pkg::CFG_TIMEOUT: hold_ticks = val;
                default:     ;
            endcase
        endfunction

        function void push(fws_pkg::t_kind k, logic [3:0] t, logic f, logic e);
            t_result r;
            r.kind = k;
            r.tag = t;
            r.fua = f;
            r.err = e;
            r.last = 1'b0;
            owed.push_back(r);
        endfunction

        function logic [2:0] first_open(logic [2:0] s);
            if (!s[0]) return fws_pkg::SEQ_PRE;
            if (!s[1]) return fws_pkg::SEQ_DATA;
            if (!s[2]) return fws_pkg::SEQ_POST;
            return 3'b000;
        endfunction

        // Issue the waiting flush unless data in flight defers it and the wait is short.
        function void try_issue_flush();
            logic [31:0] slack;
            slack = now - since - {16'd0, hold_ticks};
            if (pside != rside || count[pside] == 0) return;
            if (data_live != 0 && slack[31]) return;
            push(fws_pkg::KIND_FLUSH, 4'd0, 1'b0, 1'b0);
            pside = ~pside;
        endfunction

        function void move_on(logic [3:0] t, logic e);
            logic [2:0] st;
            st = e ? 3'b000 : first_open(steps[t]);
            if (st == fws_pkg::SEQ_PRE || st == fws_pkg::SEQ_POST) begin
                if (count[pside] == 0) since = now;
                if (count[pside] < TAGS) begin
                    queue_mem[pside][(head[pside] + count[pside]) % TAGS] = t;
                    count[pside]++;
                end
            end else if (st == fws_pkg::SEQ_DATA) begin
                in_data[t] = 1'b1;
                data_live++;
                push(fws_pkg::KIND_DATA, t, tfua[t], 1'b0);
            end else begin
                busy[t] = 1'b0;
                in_data[t] = 1'b0;
                push(fws_pkg::KIND_DONE, t, 1'b0, e);
            end
            try_issue_flush();
        endfunction

        // Notes an accepted item; returns 1 when the block does not simply ignore it.
        function bit note_event(t_event ev);
            int   first;
            int   r;
            int   n;
            logic [3:0] t;
            logic [2:0] plan;
            first = owed.size();
            t = ev.tag;
            case (ev.action)
                fws_pkg::ACT_TICK: begin
                    now++;
                    return 1'b1;
                end
                fws_pkg::ACT_FLUSH_DONE: begin
                    if (pside == rside) return 1'b0;
                    r = rside;
                    rside = ~rside;
                    n = count[r];
                    for (int i = 0; i < n && count[r] != 0; i++) begin
                        logic [3:0] qt;
                        qt = queue_mem[r][head[r]];
                        head[r] = (head[r] + 1) % TAGS;
                        count[r]--;
                        steps[qt] = steps[qt] | first_open(steps[qt]);
                        move_on(qt, ev.err);
                    end
                end
                fws_pkg::ACT_DATA_DONE: begin
                    if (!busy[t] || !in_data[t]) return 1'b0;
                    in_data[t] = 1'b0;
                    if (data_live != 0) data_live--;
                    steps[t] = steps[t] | fws_pkg::SEQ_DATA;
                    move_on(t, ev.err);
                end
                default: begin
                    if (busy[t]) return 1'b0;
                    plan = '0;
                    if (ev.has_data) plan |= fws_pkg::SEQ_DATA;
                    if (wbc) begin
                        if (ev.want_flush) plan |= fws_pkg::SEQ_PRE;
                        if (!dev_fua && ev.want_fua) plan |= fws_pkg::SEQ_POST;
                    end
                    if (plan == 3'b000) begin
                        push(fws_pkg::KIND_FINISH, t, 1'b0, 1'b0);
                    end else if (plan == fws_pkg::SEQ_DATA) begin
                        push(fws_pkg::KIND_PASS, t, ev.want_fua & dev_fua, 1'b0);
                    end else begin
                        steps[t] = ~plan;
                        tfua[t] = ev.want_fua & dev_fua;
                        busy[t] = 1'b1;
                        in_data[t] = 1'b0;
                        move_on(t, 1'b0);
                    end
                end
            endcase
            if (owed.size() > first) owed[owed.size() - 1].last = 1'b1;
            return 1'b1;
        endfunction

        task report(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_result(t_result got);
            t_result want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result kind %0d tag %0d", got.kind, got.tag));
                return;
            end
            want = owed.pop_front();
            if (got != want)
                report($sformatf({"got kind %0d tag %0d fua %0b err %0b last %0b, ",
                                  "wanted %0d %0d %0b %0b %0b"},
                    got.kind, got.tag, got.fua, got.err, got.last,
                    want.kind, want.tag, want.fua, want.err, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [3:0]  i_req_tag;
    logic        i_has_data;
    logic        i_want_flush;
    logic        i_want_fua;
    logic        i_error;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_kind;
    logic [3:0]  o_out_tag;
    logic        o_fua_kept;
    logic        o_out_error;
    logic        o_last;

    flush_fua_write_sequencer DUT (.*);

    seq_board sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a run that never drains ends here as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver side. Results are sampled at the edge, then ready is chosen for the next
    // cycle. A long hold-off, when asked for, is counted down here so that the sender
    // keeps offering items while the block backs up.
    always @(posedge i_clk) begin
        int hold_left;
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{fws_pkg::t_kind'(o_kind), o_out_tag, o_fua_kept,
                              o_out_error, o_last});
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one item and returns once it has been accepted. The predictor is updated at
    // the accepting edge, before anything is decided about the next item.
    task automatic offer(t_event ev, output bit counted);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_action     <= ev.action;
        i_req_tag    <= ev.tag;
        i_has_data   <= ev.has_data;
        i_want_flush <= ev.want_flush;
        i_want_fua   <= ev.want_fua;
        i_error      <= ev.err;
        do @(posedge i_clk); while (!o_ready);
        counted = sb.note_event(ev);
    endtask

    task automatic offer_one(fws_pkg::t_action a, int tag, bit d, bit f, bit u, bit e);
        bit unused;
        offer('{a, 4'(tag), d, f, u, e}, unused);
    endtask

    // Waits until every predicted result has come back and the block has settled.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(bit wbc, bit fua, logic [15:0] tmo);
        i_cfg_we <= 1'b1; i_cfg_idx <= fws_pkg::CFG_WBC; i_cfg_data <= {15'd0, wbc};
        @(posedge i_clk);
        sb.set_reg(fws_pkg::CFG_WBC, {15'd0, wbc});
        i_cfg_idx <= fws_pkg::CFG_FUA; i_cfg_data <= {15'd0, fua};
        @(posedge i_clk);
        sb.set_reg(fws_pkg::CFG_FUA, {15'd0, fua});
        i_cfg_idx <= fws_pkg::CFG_TIMEOUT; i_cfg_data <= tmo;
        @(posedge i_clk);
        sb.set_reg(fws_pkg::CFG_TIMEOUT, tmo);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Builds a random item. Most are well formed: inserts on free tags, data-done events
    // for tags in their data step, and flush-done events only while a flush is out.
    // The remainder is noise with every field random.
    function automatic t_event pick_event();
        t_event ev;
        int     roll;
        int     t;
        ev.action     = fws_pkg::t_action'($urandom_range(3));
        ev.tag        = 4'($urandom_range(15));
        ev.has_data   = 1'($urandom_range(1));
        ev.want_flush = 1'($urandom_range(1));
        ev.want_fua   = 1'($urandom_range(1));
        ev.err        = ($urandom_range(9) == 0);
        if ($urandom_range(99) < 12) return ev;
        roll = $urandom_range(99);
        if (roll < 30 && sb.pside != sb.rside) begin
            ev.action = fws_pkg::ACT_FLUSH_DONE;
            return ev;
        end
        if (roll < 60) begin
            t = $urandom_range(15);
            for (int i = 0; i < TAGS; i++) begin
                if (sb.busy[(t + i) % TAGS] && sb.in_data[(t + i) % TAGS]) begin
                    ev.action = fws_pkg::ACT_DATA_DONE;
                    ev.tag = 4'((t + i) % TAGS);
                    return ev;
                end
            end
        end
        if (roll < 72) begin
            ev.action = fws_pkg::ACT_TICK;
            return ev;
        end
        ev.action = fws_pkg::ACT_INSERT;
        t = $urandom_range(15);
        for (int i = 0; i < TAGS; i++) begin
            if (!sb.busy[(t + i) % TAGS]) begin
                ev.tag = 4'((t + i) % TAGS);
                break;
            end
        end
        return ev;
    endfunction

    task automatic random_phase(int items, int pressure);
        int done_items;
        bit counted;
        done_items = 0;
        while (done_items < items) begin
            if (pressure == 1 && done_items == items / 3) hold_request = 400;
            if (pressure == 2 && done_items == items / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.owed.size() != 0) @(posedge i_clk);
            end
            offer(pick_event(), counted);
            if (counted) done_items++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = fws_pkg::CFG_WBC;
        i_cfg_data   = '0;
        i_valid      = 1'b0;
        i_action     = fws_pkg::ACT_TICK;
        i_req_tag    = '0;
        i_has_data   = 1'b0;
        i_want_flush = 1'b0;
        i_want_fua   = 1'b0;
        i_error      = 1'b0;
        i_ready      = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: no write cache, so requests either finish or pass straight
        // through. Stray completions are ignored and a tick gives no result.
        offer_one(fws_pkg::ACT_INSERT, 0, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_INSERT, 15, 1, 1, 1, 1);
        offer_one(fws_pkg::ACT_TICK, 0, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_FLUSH_DONE, 0, 0, 0, 0, 1);
        offer_one(fws_pkg::ACT_DATA_DONE, 3, 0, 0, 0, 0);
        drain();

        // Write cache without FUA and a zero timeout: full preflush, data, postflush runs.
        write_regs(1'b1, 1'b0, 16'd0);
        offer_one(fws_pkg::ACT_INSERT, 1, 1, 1, 0, 0);  // preflush goes out at once
        offer_one(fws_pkg::ACT_INSERT, 1, 1, 0, 0, 0);  // same tag still busy: ignored
        offer_one(fws_pkg::ACT_INSERT, 2, 1, 0, 1, 0);  // data first, postflush later
        offer_one(fws_pkg::ACT_FLUSH_DONE, 0, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_DATA_DONE, 2, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_DATA_DONE, 1, 0, 0, 0, 1);  // data error ends the request
        offer_one(fws_pkg::ACT_FLUSH_DONE, 0, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_INSERT, 3, 0, 1, 0, 0);
        offer_one(fws_pkg::ACT_FLUSH_DONE, 0, 0, 0, 0, 1);  // flush error completes the waiter
        offer_one(fws_pkg::ACT_INSERT, 4, 0, 0, 1, 0);
        offer_one(fws_pkg::ACT_TICK, 0, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_FLUSH_DONE, 0, 0, 0, 0, 0);
        offer_one(fws_pkg::ACT_INSERT, 5, 0, 0, 0, 0);
        drain();

        // Random phases, each under its own register setting and idling pattern.
        write_regs(1'b1, 1'b0, 16'd3);
        random_phase(95, 1);
        drain();

        write_regs(1'b1, 1'b1, 16'hFFFF);
        send_idle_pct = 60;
        random_phase(95, 0);
        drain();

        write_regs(1'b0, 1'b1, 16'd500);
        send_idle_pct = 0;
        recv_stall_pct = 60;
        random_phase(95, 2);
        drain();

        write_regs(1'b1, 1'b0, 16'd0);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        random_phase(95, 0);
        drain();

        if (sb.mismatches == 0 && sb.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/fws_pkg.sv
hw/rtl/fws_wait_ram.sv
hw/rtl/flush_fua_write_sequencer.sv
hw/rtl/fws_checker.sv
sim/tb_flush_fua_write_sequencer.sv
